[hdl/fpsa_pkg.sv]
// ============================================================================
// fpsa_pkg
// Shared types and constants for the fixed pool slot allocator: request
// operation codes, slot field width and the stack control and status words.
// ============================================================================
package fpsa_pkg;

    // width of the slot fields on the request and response words
    localparam int SLOT_W = 5;

    // request operation codes
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // commands from the request stage to the free stack
    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

    // free stack status seen by the request stage
    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

endpackage

[hdl/fpsa_req_if.sv]
// ============================================================================
// fpsa_req_if
// Request channel: valid/ready handshake carrying one operation and slot word.
// ============================================================================
interface fpsa_req_if;
    import fpsa_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [SLOT_W-1:0]    slot;

    modport source (output valid, output operation, output slot, input ready);
    modport sink   (input valid, input operation, input slot, output ready);

endinterface

[hdl/fpsa_rsp_if.sv]
// ============================================================================
// fpsa_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ============================================================================
interface fpsa_rsp_if;
    import fpsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [SLOT_W-1:0]    slot_out;

    modport source (output valid, output ok, output slot_out, input ready);
    modport sink   (input valid, input ok, input slot_out, output ready);

endinterface

[hdl/fpsa_ram.sv]
// ============================================================================
// fpsa_ram
// Generic single write port, single read port RAM with registered read data.
// A read of the address being written returns the old contents.
// ============================================================================
module fpsa_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage array and read register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/fpsa_stack.sv]
// ============================================================================
// fpsa_stack
// LIFO of free slot indices. The top entry lives in a register; the entries
// beneath it live in a RAM, and the entry just below the top is prefetched
// every cycle so that it is ready when a pop comes. Entries below the lowest
// depth ever reached since reset were never written and read as their index.
// ============================================================================
module fpsa_stack #(
    parameter  int SLOTS = 32,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpsa_pkg::stack_cmd_t  cmd,
    input  logic [IDX_W-1:0]      push_data,
    output logic [IDX_W-1:0]      top,
    output fpsa_pkg::stack_stat_t stat
);
    import fpsa_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] low_reg, low_next;
    logic [IDX_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] pf_idx_reg, pf_idx_next;
    logic             pf_pristine_reg, pf_pristine_next;
    logic             pf_fwd_reg;
    logic [IDX_W-1:0] pf_data_reg;
    logic [CNT_W-1:0] pf_cnt;
    logic [IDX_W-1:0] ram_q;
    logic [IDX_W-1:0] below;
    logic             do_pop, do_push;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // entry below the top: forwarded push, untouched reset value or RAM word
    assign below = pf_fwd_reg      ? pf_data_reg :
                   pf_pristine_reg ? pf_idx_reg  : ram_q;

    // stack pointer, top register and prefetch address
    always_comb
    begin
        do_pop     = cmd.pop  && (count_reg != '0);
        do_push    = cmd.push && (count_reg != CNT_W'(SLOTS));
        count_next = count_reg;
        top_next   = top_reg;
        if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
            top_next   = below;
        end
        else if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = push_data;
        end
        low_next = (count_next < low_reg) ? count_next : low_reg;

        // old top moves down into the RAM on a push
        wr_en   = do_push && (count_reg != '0);
        wr_addr = IDX_W'(count_reg - CNT_W'(1));

        pf_cnt           = count_next - CNT_W'(2);
        pf_idx_next      = IDX_W'(pf_cnt);
        pf_pristine_next = pf_cnt < low_next;
    end

    // control and top state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= CNT_W'(SLOTS);
            low_reg         <= CNT_W'(SLOTS);
            top_reg         <= IDX_W'(SLOTS - 1);
            pf_idx_reg      <= IDX_W'(SLOTS - 2);
            pf_pristine_reg <= 1'b1;
            pf_fwd_reg      <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            low_reg         <= low_next;
            top_reg         <= top_next;
            pf_idx_reg      <= pf_idx_next;
            pf_pristine_reg <= pf_pristine_next;
            pf_fwd_reg      <= wr_en;
        end
    end

    // bypass for a word written to the address being prefetched
    always_ff @(posedge clk)
    begin
        pf_data_reg <= top_reg;
    end

    fpsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (pf_idx_next),
        .rd_data (ram_q)
    );

    assign top        = top_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(SLOTS));

endmodule

[hdl/fixed_pool_slot_allocator.sv]
// ============================================================================
// fixed_pool_slot_allocator
// Hands out slots of a fixed pool from a LIFO free list and takes them back.
// ============================================================================
// One request word gives exactly one response word. Allocate pops the most
// recently freed slot (after reset the highest index comes first) and returns
// it with ok set, or ok clear and slot 0 when the pool is empty. Release of a
// slot that is in use pushes it back and echoes it with ok set; release of a
// slot that is free or out of range answers ok clear and slot 0 and changes
// nothing. The block takes one request every cycle while responses are taken:
// a request sits in the input register, where the stack top and the in-use bit
// are updated in a single pass, and then waits in the result register. The
// stack top is kept in a register and the entry below it is prefetched from
// the RAM each cycle, so back-to-back pops run at full rate. No clearing pass
// is needed after reset; requests are taken at once.
module fixed_pool_slot_allocator #(
    parameter int SLOTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fpsa_req_if.sink   req,
    fpsa_rsp_if.source rsp
);
    import fpsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [SLOTS-1:0]  in_use_reg, in_use_next;
    logic              advance;
    logic              accept;
    logic              rel_in_range;
    logic [IDX_W-1:0]  rel_idx;
    logic [IDX_W-1:0]  top;
    logic              alloc_ok, release_ok;
    logic              res_ok;
    logic [SLOT_W-1:0] res_slot;
    stack_cmd_t        stack_cmd;
    stack_stat_t       stack_stat;

    // handshake: a word moves on whenever the result register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    // decision on the word in the input register
    always_comb
    begin
        rel_in_range = CMP_W'(in_slot_reg) < CMP_W'(SLOTS);
        rel_idx      = IDX_W'(in_slot_reg);
        alloc_ok     = (in_op_reg == OP_ALLOC) && !stack_stat.empty;
        release_ok   = (in_op_reg == OP_RELEASE) && rel_in_range &&
                       in_use_reg[rel_idx] && !stack_stat.full;

        stack_cmd.pop  = advance && alloc_ok;
        stack_cmd.push = advance && release_ok;

        res_ok = alloc_ok || release_ok;
        if (alloc_ok)
        begin
            res_slot = SLOT_W'(top);
        end
        else if (release_ok)
        begin
            res_slot = in_slot_reg;
        end
        else
        begin
            res_slot = '0;
        end
    end

    // in-use bits
    always_comb
    begin
        in_use_next = in_use_reg;
        if (stack_cmd.pop)
        begin
            in_use_next[top] = 1'b1;
        end
        if (stack_cmd.push)
        begin
            in_use_next[rel_idx] = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_use_reg    <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            in_use_reg <= in_use_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= req.operation;
            in_slot_reg <= req.slot;
        end
        if (advance)
        begin
            out_ok_reg   <= res_ok;
            out_slot_reg <= res_slot;
        end
    end

    fpsa_stack #(
        .SLOTS (SLOTS)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stack_cmd),
        .push_data (rel_idx),
        .top       (top),
        .stat      (stack_stat)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.ok       = out_ok_reg;
    assign rsp.slot_out = out_slot_reg;

endmodule

[hdl/fpsa_checker.sv]
// ============================================================================
// fpsa_checker
// Port-level checks on the slot allocator's request and response channels,
// bound to the top level.
// ============================================================================
module fpsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_ok,
    input logic [fpsa_pkg::SLOT_W-1:0] rsp_slot_out
);
    import fpsa_pkg::*;

    // a fresh response word is preceded by an accepted request
    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response word appeared without a matching request");

    // with the result stalled, at most one more request word is taken
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready && req_valid && req_ready) |=>
        (!req_ready || rsp_ready))
        else $error("request taken while both stages are full");

    // a stalled response stays offered
    a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response valid dropped before it was taken");

    // a stalled response word holds its contents
    a_rsp_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(rsp_ok) && $stable(rsp_slot_out)))
        else $error("response word changed while stalled");

endmodule

bind fixed_pool_slot_allocator fpsa_checker u_fpsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_slot_out (rsp.slot_out)
);
